/* rtl/hsv_pkg.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Shared widths, stage control type and divider constants.
// ----------------------------------------------------------------------------
package hsv_pkg;

    // Field widths of the transfer payloads.
    localparam int HUE_W  = 10;
    localparam int FRAC_W = 9;
    localparam int CH_W   = 8;

    // Weight applied to saturation per channel, 0 to 60.
    localparam int WGT_W = 7;

    // Final divide by 15 done as a multiply by a rounded-up reciprocal.
    // The error stays below one unit for every dividend under 4096.
    localparam int                DIVQ_W      = 12;
    localparam int                RECIP_W     = 15;
    localparam logic [RECIP_W-1:0] RECIP_15   = 15'd17477;
    localparam int                RECIP_SHIFT = 18;
    localparam int                RPROD_W     = DIVQ_W + RECIP_W;

    // Load enables of the six pipeline stages.
    typedef struct packed {
        logic ld_wrap;
        logic ld_sector;
        logic ld_weight;
        logic ld_prod;
        logic ld_scale;
        logic ld_div;
    } hsv_ctrl_t;

endpackage

/* rtl/hsv_if.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter channels
// Valid/ready interfaces for the HSV input and the RGB output.
// ----------------------------------------------------------------------------
interface hsv_in_if;
    import hsv_pkg::*;

    logic              valid;
    logic              ready;
    logic [HUE_W-1:0]  hue;
    logic [FRAC_W-1:0] saturation;
    logic [FRAC_W-1:0] brightness;

    modport source (output valid, output hue, output saturation, output brightness,
                    input ready);
    modport sink   (input valid, input hue, input saturation, input brightness,
                    output ready);
endinterface

interface hsv_out_if;
    import hsv_pkg::*;

    logic            valid;
    logic            ready;
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;

    modport source (output valid, output red, output green, output blue,
                    input ready);
    modport sink   (input valid, input red, input green, input blue,
                    output ready);
endinterface

/* rtl/hsv_to_rgb_converter.sv */
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Six-stage pipeline turning hue, saturation and value into 8-bit RGB.
// ----------------------------------------------------------------------------
// Usage: colors enter on the hsv channel (hue in degrees, saturation and
// brightness with 1 << FRACTION_BITS meaning full scale) and leave on the
// rgb channel as truncated 8-bit red, green and blue. Every transfer on hsv
// produces exactly one transfer on rgb, in order.
//
// Throughput is one color per cycle while rgb.ready stays high; the work is
// spread over six register stages, each of which holds one color: wrap and
// clamp, sector select, weight product, value product, scaling, and the
// final divide by fifteen.
//
// When the receiver holds rgb.ready low the last stage keeps its result and
// each stage stops only if the stage after it is full, so bubbles close up
// and the input keeps taking transfers until all six stages hold a color.
// hsv.ready depends combinationally on rgb.ready through that chain.
//
// Reset clears all stage valid bits; the block is ready right after reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter #(
    parameter int FRACTION_BITS = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    hsv_in_if.sink    hsv,
    hsv_out_if.source rgb
);
    import hsv_pkg::*;

    localparam int NUM_STAGES = 6;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] ld;
    hsv_ctrl_t             ctrl;

    logic [WGT_W-1:0]       w_red, w_green, w_blue;
    logic [FRACTION_BITS:0] sat, val;

    // A stage loads when it is empty or its content moves on this cycle.
    always_comb
    begin
        ld[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || rgb.ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            ld[i] = !vld_reg[i] || ld[i+1];
        end
        vld_next[0] = ld[0] ? hsv.valid : vld_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            if (ld[i])
            begin
                vld_next[i] = vld_reg[i-1];
            end
            else
            begin
                vld_next[i] = vld_reg[i];
            end
        end
    end

    assign ctrl.ld_wrap   = ld[0];
    assign ctrl.ld_sector = ld[1];
    assign ctrl.ld_weight = ld[2];
    assign ctrl.ld_prod   = ld[3];
    assign ctrl.ld_scale  = ld[4];
    assign ctrl.ld_div    = ld[5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign hsv.ready = ld[0];
    assign rgb.valid = vld_reg[NUM_STAGES-1];

    hsv_front #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk        (clk),
        .ctrl       (ctrl),
        .hue        (hsv.hue),
        .saturation (hsv.saturation),
        .brightness (hsv.brightness),
        .w_red      (w_red),
        .w_green    (w_green),
        .w_blue     (w_blue),
        .sat        (sat),
        .val        (val)
    );

    hsv_chan #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_chan_red (
        .clk  (clk),
        .ctrl (ctrl),
        .wgt  (w_red),
        .sat  (sat),
        .val  (val),
        .ch   (rgb.red)
    );

    hsv_chan #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_chan_green (
        .clk  (clk),
        .ctrl (ctrl),
        .wgt  (w_green),
        .sat  (sat),
        .val  (val),
        .ch   (rgb.green)
    );

    hsv_chan #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_chan_blue (
        .clk  (clk),
        .ctrl (ctrl),
        .wgt  (w_blue),
        .sat  (sat),
        .val  (val),
        .ch   (rgb.blue)
    );

    // The number of colors in flight changes only by transfers at the ports.
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> $countones(vld_reg) == $past($countones(vld_reg))
                 + $past(int'(hsv.valid && hsv.ready))
                 - $past(int'(rgb.valid && rgb.ready)))
        else $error("pipeline occupancy does not match the transfers");

    // A stalled result must not be overwritten.
    a_hold_output: assert property (@(posedge clk) disable iff (!rst_n)
        rgb.valid && !rgb.ready |-> !ctrl.ld_div)
        else $error("output stage loads while its result is stalled");

    // A color never waits in front of an empty stage.
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[0] && !vld_reg[1] |=> vld_reg[1])
        else $error("first stage did not advance into an empty stage");

endmodule

/* rtl/hsv_front.sv */
// ----------------------------------------------------------------------------
// HSV front end
// Clamps saturation and value, wraps the hue and picks the per-channel
// saturation weight from the hue sector.
// ----------------------------------------------------------------------------
module hsv_front #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                           clk,
    input  hsv_pkg::hsv_ctrl_t             ctrl,
    input  logic [hsv_pkg::HUE_W-1:0]      hue,
    input  logic [hsv_pkg::FRAC_W-1:0]     saturation,
    input  logic [hsv_pkg::FRAC_W-1:0]     brightness,
    output logic [hsv_pkg::WGT_W-1:0]      w_red,
    output logic [hsv_pkg::WGT_W-1:0]      w_green,
    output logic [hsv_pkg::WGT_W-1:0]      w_blue,
    output logic [FRACTION_BITS:0]         sat,
    output logic [FRACTION_BITS:0]         val
);
    import hsv_pkg::*;

    localparam int EXT_W = (FRAC_W > FRACTION_BITS + 1) ? FRAC_W : FRACTION_BITS + 1;
    localparam logic [EXT_W-1:0] ONE_EXT = EXT_W'(1) << FRACTION_BITS;

    localparam logic [2:0] SECT_0    = 3'd0;
    localparam logic [2:0] SECT_1    = 3'd1;
    localparam logic [2:0] SECT_2    = 3'd2;
    localparam logic [2:0] SECT_3    = 3'd3;
    localparam logic [2:0] SECT_4    = 3'd4;
    localparam logic [2:0] SECT_5    = 3'd5;
    localparam logic [2:0] SECT_NONE = 3'd6;

    localparam logic [WGT_W-1:0] W_ZERO = 7'd0;
    localparam logic [WGT_W-1:0] W_FULL = 7'd60;

    // Stage 1 registers.
    logic [HUE_W-1:0]       hue_reg;
    logic [HUE_W-1:0]       hue_next;
    logic [FRACTION_BITS:0] sat1_reg;
    logic [FRACTION_BITS:0] sat1_next;
    logic [FRACTION_BITS:0] val1_reg;
    logic [FRACTION_BITS:0] val1_next;

    // Stage 2 registers.
    logic [WGT_W-1:0]       wr_reg, wr_next;
    logic [WGT_W-1:0]       wg_reg, wg_next;
    logic [WGT_W-1:0]       wb_reg, wb_next;
    logic [FRACTION_BITS:0] sat2_reg;
    logic [FRACTION_BITS:0] val2_reg;

    logic [EXT_W-1:0] sat_ext;
    logic [EXT_W-1:0] val_ext;
    logic [2:0]       sect;
    logic [HUE_W-1:0] base;
    logic [5:0]       offset;
    logic [WGT_W-1:0] hue_dist;

    always_comb
    begin
        sat_ext   = EXT_W'(saturation);
        val_ext   = EXT_W'(brightness);
        sat1_next = (sat_ext > ONE_EXT) ? (FRACTION_BITS+1)'(ONE_EXT)
                                        : (FRACTION_BITS+1)'(sat_ext);
        val1_next = (val_ext > ONE_EXT) ? (FRACTION_BITS+1)'(ONE_EXT)
                                        : (FRACTION_BITS+1)'(val_ext);
        hue_next  = (hue >= 10'd360) ? hue - 10'd360 : hue;
    end

    always_comb
    begin
        if (hue_reg < 10'd60)
        begin
            sect = SECT_0;
            base = 10'd0;
        end
        else if (hue_reg < 10'd120)
        begin
            sect = SECT_1;
            base = 10'd60;
        end
        else if (hue_reg < 10'd180)
        begin
            sect = SECT_2;
            base = 10'd120;
        end
        else if (hue_reg < 10'd240)
        begin
            sect = SECT_3;
            base = 10'd180;
        end
        else if (hue_reg < 10'd300)
        begin
            sect = SECT_4;
            base = 10'd240;
        end
        else if (hue_reg < 10'd360)
        begin
            sect = SECT_5;
            base = 10'd300;
        end
        else
        begin
            sect = SECT_NONE;
            base = 10'd0;
        end

        offset   = 6'(hue_reg - base);
        // Distance of hue mod 120 from 60: falling in even sectors, rising in odd.
        hue_dist = sect[0] ? WGT_W'(offset) : W_FULL - WGT_W'(offset);

        // Weight 0 gives the full chroma, 60 gives the bare offset M.
        case (sect)
            SECT_0:  begin wr_next = W_ZERO;   wg_next = hue_dist; wb_next = W_FULL;   end
            SECT_1:  begin wr_next = hue_dist; wg_next = W_ZERO;   wb_next = W_FULL;   end
            SECT_2:  begin wr_next = W_FULL;   wg_next = W_ZERO;   wb_next = hue_dist; end
            SECT_3:  begin wr_next = W_FULL;   wg_next = hue_dist; wb_next = W_ZERO;   end
            SECT_4:  begin wr_next = hue_dist; wg_next = W_FULL;   wb_next = W_ZERO;   end
            SECT_5:  begin wr_next = W_ZERO;   wg_next = W_FULL;   wb_next = hue_dist; end
            default: begin wr_next = W_FULL;   wg_next = W_FULL;   wb_next = W_FULL;   end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_wrap)
        begin
            hue_reg  <= hue_next;
            sat1_reg <= sat1_next;
            val1_reg <= val1_next;
        end
        if (ctrl.ld_sector)
        begin
            wr_reg   <= wr_next;
            wg_reg   <= wg_next;
            wb_reg   <= wb_next;
            sat2_reg <= sat1_reg;
            val2_reg <= val1_reg;
        end
    end

    assign w_red   = wr_reg;
    assign w_green = wg_reg;
    assign w_blue  = wb_reg;
    assign sat     = sat2_reg;
    assign val     = val2_reg;

endmodule

/* rtl/hsv_chan.sv */
// ----------------------------------------------------------------------------
// HSV channel datapath
// Computes one 8-bit color channel from its saturation weight in four
// register stages: weight product, value product, scale, divide.
// ----------------------------------------------------------------------------
module hsv_chan #(
    parameter int FRACTION_BITS = 8
) (
    input  logic                        clk,
    input  hsv_pkg::hsv_ctrl_t          ctrl,
    input  logic [hsv_pkg::WGT_W-1:0]   wgt,
    input  logic [FRACTION_BITS:0]      sat,
    input  logic [FRACTION_BITS:0]      val,
    output logic [hsv_pkg::CH_W-1:0]    ch
);
    import hsv_pkg::*;

    localparam int SW_W = FRACTION_BITS + 1 + WGT_W;
    localparam int T_W  = FRACTION_BITS + 6;
    localparam int P_W  = 2 * FRACTION_BITS + 6;
    localparam int S_W  = P_W + 8;
    localparam logic [SW_W-1:0] FULL_SCALE = SW_W'(60) << FRACTION_BITS;

    logic [T_W-1:0]           t_reg, t_next;
    logic [FRACTION_BITS:0]   v3_reg;
    logic [P_W-1:0]           p_reg, p_next;
    logic [DIVQ_W-1:0]        q_reg, q_next;
    logic [CH_W-1:0]          ch_reg, ch_next;

    logic [SW_W-1:0]    sw;
    logic [S_W-1:0]     scaled;
    logic [RPROD_W-1:0] rprod;

    always_comb
    begin
        // Numerator over 60*ONE*ONE is val * (60*ONE - sat*wgt).
        sw      = SW_W'(sat) * SW_W'(wgt);
        t_next  = T_W'(FULL_SCALE - sw);
        p_next  = P_W'(v3_reg) * P_W'(t_reg);
        // Times 255, drop ONE*ONE and a further factor of four.
        scaled  = (S_W'(p_reg) << 8) - S_W'(p_reg);
        q_next  = scaled[2*FRACTION_BITS+13:2*FRACTION_BITS+2];
        // Remaining divide by 15.
        rprod   = RPROD_W'(q_reg) * RPROD_W'(RECIP_15);
        ch_next = rprod[RECIP_SHIFT+CH_W-1:RECIP_SHIFT];
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_weight)
        begin
            t_reg  <= t_next;
            v3_reg <= val;
        end
        if (ctrl.ld_prod)
        begin
            p_reg <= p_next;
        end
        if (ctrl.ld_scale)
        begin
            q_reg <= q_next;
        end
        if (ctrl.ld_div)
        begin
            ch_reg <= ch_next;
        end
    end

    assign ch = ch_reg;

endmodule

/* bench/hsv_to_rgb_converter_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Drives colors into the converter with random sender gaps and receiver
// stalls, predicts each 8-bit RGB result in exact integer arithmetic and
// checks every result, in order, field by field.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;
    import hsv_pkg::*;

    localparam int FRACTION_BITS = 8;

    // Full scale of saturation and brightness, and the common denominator of
    // the exact six-sector formula: 60 degrees times full scale squared.
    localparam longint unsigned FULL_SCALE = longint'(1) << FRACTION_BITS;
    localparam longint unsigned DENOM      = longint'(60) << (2 * FRACTION_BITS);

    // Cycles with no transfer on either channel before the run is abandoned.
    // The slowest correct stretch is a sender gap, a receiver stall and the
    // 6-stage pipeline, so this is far above anything legitimate.
    localparam int WATCHDOG_LIMIT = 2000;

    // Cycles allowed after the last result for any stray transfer to show up.
    localparam int TAIL_CYCLES = 20;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [FRAC_W-1:0] saturation;
        logic [FRAC_W-1:0] brightness;
    } hsv_color_t;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } rgb_color_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    hsv_in_if  hsv ();
    hsv_out_if rgb ();

    hsv_to_rgb_converter #(
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .clk  (clk),
        .rst_n(rst_n),
        .hsv  (hsv),
        .rgb  (rgb)
    );

    // Colors waiting to be driven, and the RGB values still owed by the
    // converter for colors it has already taken.
    hsv_color_t pending_colors[$];
    rgb_color_t owed_rgb[$];

    // When low, neither side inserts gaps or stalls.
    bit idling_on = 1'b1;

    int send_gap       = 0;
    int stall_left     = 0;
    int quiet_cycles   = 0;
    int colors_sent    = 0;
    int results_seen   = 0;
    int mismatch_count = 0;
    int grey_hue_count = 0;
    int clamp_count    = 0;

    // The clock runs with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // One output channel: floor((primary + offset) * 255 / D), kept to 8 bits.
    function automatic logic [CH_W-1:0] channel_level(input longint unsigned primary,
                                                      input longint unsigned offset);
        longint unsigned level;
        level = ((primary + offset) * 64'd255) / DENOM;
        return level[CH_W-1:0];
    endfunction

    // Expected RGB for one color. Saturation and brightness clamp to full
    // scale, the hue wraps once, and a hue still at 360 or beyond after the
    // wrap falls in no sector, so only the grey offset remains.
    function automatic rgb_color_t hsv_to_rgb_expected(input hsv_color_t color);
        longint unsigned hue_deg;
        longint unsigned sat;
        longint unsigned bri;
        longint unsigned hue_mod;
        longint unsigned hue_dist;
        longint unsigned chroma;
        longint unsigned second;
        longint unsigned offset;
        longint unsigned red_p;
        longint unsigned green_p;
        longint unsigned blue_p;
        rgb_color_t      result;
        hue_deg = color.hue;
        sat     = (color.saturation > FULL_SCALE) ? FULL_SCALE : color.saturation;
        bri     = (color.brightness > FULL_SCALE) ? FULL_SCALE : color.brightness;
        red_p   = 0;
        green_p = 0;
        blue_p  = 0;
        if (hue_deg >= 360)
            hue_deg = hue_deg - 360;
        hue_mod  = hue_deg % 120;
        hue_dist = (hue_mod >= 60) ? (hue_mod - 60) : (60 - hue_mod);
        chroma   = bri * sat * 60;
        second   = bri * sat * (60 - hue_dist);
        offset   = bri * FULL_SCALE * 60 - chroma;
        if (hue_deg < 60)
        begin
            red_p   = chroma;
            green_p = second;
        end
        else if (hue_deg < 120)
        begin
            red_p   = second;
            green_p = chroma;
        end
        else if (hue_deg < 180)
        begin
            green_p = chroma;
            blue_p  = second;
        end
        else if (hue_deg < 240)
        begin
            green_p = second;
            blue_p  = chroma;
        end
        else if (hue_deg < 300)
        begin
            red_p  = second;
            blue_p = chroma;
        end
        else if (hue_deg < 360)
        begin
            red_p  = chroma;
            blue_p = second;
        end
        result.red   = channel_level(red_p, offset);
        result.green = channel_level(green_p, offset);
        result.blue  = channel_level(blue_p, offset);
        return result;
    endfunction

    task automatic queue_color(input int hue_deg, input int sat, input int bri);
        hsv_color_t color;
        color.hue        = hue_deg[HUE_W-1:0];
        color.saturation = sat[FRAC_W-1:0];
        color.brightness = bri[FRAC_W-1:0];
        pending_colors.push_back(color);
    endtask

    // Most random colors are legal ones (hue below 720, fractions up to full
    // scale, with the end points favored); the rest use every bit of every
    // field so that out-of-range hues and clamped fractions keep turning up.
    task automatic queue_random_colors(input int count);
        int hue_deg;
        int sat;
        int bri;
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                hue_deg = $urandom_range(0, 719);
                case ($urandom_range(0, 7))
                    0:       sat = 0;
                    1:       sat = int'(FULL_SCALE);
                    default: sat = $urandom_range(0, int'(FULL_SCALE));
                endcase
                case ($urandom_range(0, 7))
                    0:       bri = 0;
                    1:       bri = int'(FULL_SCALE);
                    default: bri = $urandom_range(0, int'(FULL_SCALE));
                endcase
            end
            else
            begin
                hue_deg = $urandom_range(0, (1 << HUE_W) - 1);
                sat     = $urandom_range(0, (1 << FRAC_W) - 1);
                bri     = $urandom_range(0, (1 << FRAC_W) - 1);
            end
            queue_color(hue_deg, sat, bri);
        end
    endtask

    // Holds the sender back until every queued color has been taken and every
    // owed result has come out. Sampling at the falling edge keeps clear of
    // the updates made at the rising edge.
    task automatic wait_for_drain();
        do
            @(negedge clk);
        while (pending_colors.size() != 0 || hsv.valid || owed_rgb.size() != 0);
    endtask

    // Driver: presents the next pending color, unless a sender gap is running,
    // whenever the current one has been transferred or nothing is being offered.
    // The expected result is computed from the payload seen at the accepting
    // edge, so it always matches what the converter actually took.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hsv.valid      <= 1'b0;
            hsv.hue        <= '0;
            hsv.saturation <= '0;
            hsv.brightness <= '0;
            send_gap       = 0;
        end
        else
        begin
            if (hsv.valid && hsv.ready)
            begin
                hsv_color_t taken;
                taken.hue        = hsv.hue;
                taken.saturation = hsv.saturation;
                taken.brightness = hsv.brightness;
                owed_rgb.push_back(hsv_to_rgb_expected(taken));
                colors_sent++;
                if (taken.hue >= 720)
                    grey_hue_count++;
                if (taken.saturation > FULL_SCALE || taken.brightness > FULL_SCALE)
                    clamp_count++;
            end
            if (!hsv.valid || hsv.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    hsv.valid <= 1'b0;
                end
                else if (pending_colors.size() != 0)
                begin
                    hsv_color_t next_color;
                    next_color = pending_colors.pop_front();
                    hsv.valid      <= 1'b1;
                    hsv.hue        <= next_color.hue;
                    hsv.saturation <= next_color.saturation;
                    hsv.brightness <= next_color.brightness;
                    // A gap that starts after this transfer, sometimes.
                    if (idling_on && $urandom_range(0, 5) == 0)
                        send_gap = $urandom_range(1, 3);
                end
                else
                begin
                    hsv.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: checks every RGB transfer against the oldest owed result and
    // throws in random stall bursts on ready.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rgb.ready  <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (rgb.valid && rgb.ready)
            begin
                results_seen++;
                if (owed_rgb.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: unexpected rgb result r=%0d g=%0d b=%0d",
                                 $realtime, rgb.red, rgb.green, rgb.blue);
                end
                else
                begin
                    rgb_color_t want;
                    want = owed_rgb.pop_front();
                    if (rgb.red !== want.red || rgb.green !== want.green
                        || rgb.blue !== want.blue)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("%0t: rgb mismatch expected r=%0d g=%0d b=%0d",
                                     $realtime, want.red, want.green, want.blue,
                                     ", got r=%0d g=%0d b=%0d",
                                     rgb.red, rgb.green, rgb.blue);
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rgb.ready <= 1'b0;
            end
            else
            begin
                rgb.ready <= 1'b1;
                if (idling_on && $urandom_range(0, 5) == 0)
                    stall_left = $urandom_range(1, 3);
            end
        end
    end

    // Watchdog: a run that stops moving is a failure, not a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((hsv.valid && hsv.ready) || (rgb.valid && rgb.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog expired with %0d results still owed", owed_rgb.size());
                $display("hsv_to_rgb_converter regression: fail");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // Directed colors: both edges of every sector at full saturation and
        // brightness, the single hue wrap, hues that stay out of range after
        // the wrap (pure grey), zero saturation, zero brightness, fractions
        // just above and far above full scale, and all-ones fields.
        queue_color(0, 256, 256);
        queue_color(59, 256, 256);
        queue_color(60, 256, 256);
        queue_color(119, 256, 256);
        queue_color(120, 256, 256);
        queue_color(179, 256, 256);
        queue_color(180, 256, 256);
        queue_color(239, 256, 256);
        queue_color(240, 256, 256);
        queue_color(299, 256, 256);
        queue_color(300, 256, 256);
        queue_color(359, 256, 256);
        queue_color(360, 256, 256);
        queue_color(719, 256, 256);
        queue_color(720, 200, 180);
        queue_color(1023, 511, 511);
        queue_color(90, 0, 200);
        queue_color(200, 300, 0);
        queue_color(30, 257, 257);
        queue_color(0, 0, 0);
        queue_color(1023, 0, 0);
        queue_color(150, 128, 255);
        queue_color(330, 1, 1);

        // The sender stays quiet until the directed colors have all come out.
        wait_for_drain();

        queue_random_colors(800);
        wait_for_drain();

        queue_random_colors(700);
        wait_for_drain();

        // Last stretch at full rate on both sides.
        idling_on = 1'b0;
        queue_random_colors(380);
        wait_for_drain();

        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent %0d colors and checked %0d rgb results.", colors_sent, results_seen);
        $display("%0d colors had a hue past 719, %0d had a clamped fraction; %0d mismatches.",
                 grey_hue_count, clamp_count, mismatch_count);
        if (mismatch_count == 0 && owed_rgb.size() == 0)
            $display("hsv_to_rgb_converter regression: pass");
        else
            $display("hsv_to_rgb_converter regression: fail");
        $finish;
    end

endmodule

/* files.f */
rtl/hsv_pkg.sv
rtl/hsv_if.sv
rtl/hsv_front.sv
rtl/hsv_chan.sv
rtl/hsv_to_rgb_converter.sv
bench/hsv_to_rgb_converter_tb.sv
